// ===== design/ipc_pkg.sv =====
// ipc_pkg: shared constants, types and mask helper for the prefix classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ipc_pkg;
  localparam int NUM_CX       = 8;
  localparam int RULES_PER_CX = 8;
  localparam int SLOTS        = NUM_CX * RULES_PER_CX;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CX_W         = 3;
  localparam int START_W      = 4;

  localparam logic       OP_WRITE    = 1'b0;
  localparam logic       OP_CLASSIFY = 1'b1;
  localparam logic [1:0] AT_UNICAST  = 2'd0;
  localparam logic [1:0] AT_SIGNAL   = 2'd1;
  localparam logic [1:0] AT_MBMS     = 2'd2;
  localparam logic [1:0] AT_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [5:0]  dscp;
    logic [1:0]  version;
    logic [7:0]  plen;
    logic        valid;
  } rule_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [5:0]  dscp;
  } key_t;

  function automatic logic [127:0] prefix_mask(input logic [7:0] p);
    logic [127:0] m;
    begin
      if (p >= 8'd128) m = '1;
      else m = ~({128{1'b1}} >> p);
      return m;
    end
  endfunction
endpackage
`default_nettype wire

// ===== design/ipv6_prefix_classifier.sv =====
// ipv6_prefix_classifier: top level; rule chain of SLOTS cells, scan control
// and output register. Depends on ipc_pkg, ipc_cell, ipc_match.
//
// channel | dir | handshake        | payload
// in      | in  | in_tvalid/tready | in_tdata (160 bits), in_tuser (operation)
// out     | out | out_tvalid/tready| out_tdata (found,cx,next), out_tuser (type)
//
// Write and multicast: result is set on accept. Unicast: the chain rotates a full
// turn of SLOTS cells (64) so the table returns to its place; the first hit from
// start_cx is latched. Result sits in an output register; next request is taken
// when the output is free. Reset clears valid marks and control only.
`timescale 1ns / 1ps
`default_nettype none
module ipv6_prefix_classifier (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // dest_hi[63:0], dest_lo[127:64], dscp[133:128], start_cx[137:134],
  // slot_index[143:138], rule_version[145:144], rule_prefix_len[153:146],
  // rule_enable[154], zero fill
  input  wire logic [159:0] in_tdata,
  // operation
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // found[0], cx_index[3:1], next_start[7:4]
  output logic [7:0]        out_tdata,
  // addr_type
  output logic [1:0]        out_tuser
);
  import ipc_pkg::*;
  typedef enum logic {S_IDLE, S_SCAN} state_t;
  state_t state_r;
  logic [SLOT_W-1:0] cnt_r;
  key_t key_r;
  logic [START_W-1:0] start_r;
  logic found_r;
  logic [CX_W-1:0] cx_r;
  logic ov_r, of_r;
  logic [CX_W-1:0] ocx_r;
  logic [START_W-1:0] onext_r;
  logic [1:0] otype_r;

  logic [63:0] d_hi, d_lo;
  logic [5:0] d_dscp, d_slot;
  logic [3:0] d_start;
  logic [1:0] d_ver;
  logic [7:0] d_plen;
  logic d_en;
  assign d_hi = in_tdata[63:0];
  assign d_lo = in_tdata[127:64];
  assign d_dscp = in_tdata[133:128];
  assign d_start = in_tdata[137:134];
  assign d_slot = in_tdata[143:138];
  assign d_ver = in_tdata[145:144];
  assign d_plen = in_tdata[153:146];
  assign d_en = in_tdata[154];

  logic acc, shift, hit;
  rule_t chain [SLOTS];
  rule_t wr_rule;
  assign in_tready = rst_n && (state_r == S_IDLE) && !ov_r;
  assign acc = in_tvalid && in_tready;
  assign shift = (state_r == S_SCAN);
  assign wr_rule = '{hi: d_hi, lo: d_lo, dscp: d_dscp, version: d_ver, plen: d_plen,
                     valid: d_en};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ipc_cell u_cell (
      .clk, .rst_n, .shift,
      .load(acc && in_tuser == OP_WRITE && d_slot == SLOT_W'(i)),
      .load_rule(wr_rule),
      .prev_rule(chain[(i + 1) % SLOTS]),
      .rule(chain[i])
    );
  end

  ipc_match u_match (.rule(chain[0]), .key(key_r), .hit);

  logic [CX_W-1:0] cur_cx;
  logic [START_W-1:0] cur_cx4;
  assign cur_cx  = CX_W'(cnt_r / RULES_PER_CX);
  assign cur_cx4 = START_W'(cnt_r / RULES_PER_CX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (acc) begin
          if (in_tuser == OP_WRITE) begin
            ov_r <= 1'b1; otype_r <= AT_UNICAST; of_r <= 1'b0;
            ocx_r <= '0; onext_r <= '0;
          end else if (d_hi[63:56] == 8'hFF) begin
            ov_r <= 1'b1; of_r <= 1'b0; ocx_r <= '0; onext_r <= d_start;
            if (d_hi[51:48] == 4'h2) otype_r <= AT_SIGNAL;
            else if (d_hi[51:48] == 4'hE) otype_r <= AT_MBMS;
            else otype_r <= AT_UNKNOWN;
          end else begin
            state_r <= S_SCAN;
            key_r <= '{hi: d_hi, lo: d_lo, dscp: d_dscp};
            start_r <= d_start; cnt_r <= '0; found_r <= 1'b0; cx_r <= '0;
          end
        end
        S_SCAN: begin
          if (!found_r && hit && cur_cx4 >= start_r) begin
            found_r <= 1'b1; cx_r <= cur_cx;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == SLOT_W'(SLOTS - 1)) begin
            state_r <= S_IDLE;
            ov_r <= 1'b1; otype_r <= AT_UNICAST;
            if (!found_r && hit && cur_cx4 >= start_r) begin
              of_r <= 1'b1; ocx_r <= cur_cx; onext_r <= cur_cx4 + 1'b1;
            end else if (found_r) begin
              of_r <= 1'b1; ocx_r <= cx_r; onext_r <= {1'b0, cx_r} + 1'b1;
            end else begin
              of_r <= 1'b0; ocx_r <= '0;
              onext_r <= (start_r >= START_W'(NUM_CX)) ? start_r : START_W'(NUM_CX);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {onext_r, ocx_r, of_r};
  assign out_tuser = otype_r;
endmodule
`default_nettype wire

// ===== design/ipc_cell.sv =====
// ipc_cell: one rule slot in the scan chain; stores a rule and shifts it to
// its neighbor while a scan rotates the table. Depends on ipc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipc_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           shift,
  input  wire logic           load,
  input  ipc_pkg::rule_t      load_rule,
  input  ipc_pkg::rule_t      prev_rule,
  output ipc_pkg::rule_t      rule
);
  import ipc_pkg::*;
  rule_t rule_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rule_r.valid <= 1'b0;
    else if (shift) rule_r <= prev_rule;
    else if (load) rule_r <= load_rule;
  end
  assign rule = rule_r;
endmodule
`default_nettype wire

// ===== design/ipc_match.sv =====
// ipc_match: compares the rule at the head of the chain with the search key.
// Depends on ipc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipc_match (
  input  ipc_pkg::rule_t rule,
  input  ipc_pkg::key_t  key,
  output logic           hit
);
  import ipc_pkg::*;
  logic [127:0] m;
  always_comb begin
    m   = prefix_mask(rule.plen);
    hit = rule.valid && (rule.dscp == key.dscp) &&
          (rule.version == 2'd1 || rule.version == 2'd2) &&
          ({key.hi, key.lo} != 128'd0) &&
          ((({key.hi, key.lo} ^ {rule.hi, rule.lo}) & m) == 128'd0);
  end
endmodule
`default_nettype wire

// ===== design/ipc_checker.sv =====
// ipc_checker: port-level checks for ipv6_prefix_classifier, bound to the top.
// Depends on ipc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [1:0] out_tuser
);
  import ipc_pkg::*;
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("request taken with result pending");
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_WRITE |=> out_tvalid && out_tdata == 8'd0
    && out_tuser == AT_UNICAST) else $error("write result not zero");
  a_mc_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != AT_UNICAST |-> !out_tdata[0])
    else $error("multicast reported found");
endmodule
bind ipv6_prefix_classifier ipc_checker u_ipc_checker (.*);
`default_nettype wire

// ===== tb/sv/ipc_checker.sv =====
// ipc_scoreboard: watches the request and result channels of the prefix
// classifier, predicts each result from a private copy of the rule table.
// Depends on ipc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipc_scoreboard
  import ipc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [159:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [7:0]   out_tdata,
  input  wire logic [1:0]   out_tuser,
  output int                fail_count,
  output int                pending
);
  typedef struct packed {
    logic [1:0] addr_type;
    logic       found;
    logic [2:0] cx;
    logic [3:0] next_start;
  } verdict_t;

  rule_t    table_q[SLOTS];
  verdict_t verdicts_q[$];

  assign pending = verdicts_q.size();

  function automatic logic [127:0] plen_mask(logic [7:0] p);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < 128; i++) if (i < p) m[127 - i] = 1'b1;
    return m;
  endfunction

  function automatic verdict_t classify(logic op, logic [159:0] d);
    verdict_t v;
    logic [127:0] addr, m;
    logic [5:0] ds;
    logic [3:0] st;
    logic [5:0] idx;
    v = '0;
    addr = {d[63:0], d[127:64]};
    ds = d[133:128];
    st = d[137:134];
    idx = d[143:138];
    if (op == OP_WRITE) begin
      table_q[idx] = '{hi: d[63:0], lo: d[127:64], dscp: ds, version: d[145:144],
                       plen: d[153:146], valid: d[154]};
    end else if (addr[127:120] == 8'hFF) begin
      case (addr[115:112])
        4'h2: v.addr_type = AT_SIGNAL;
        4'hE: v.addr_type = AT_MBMS;
        default: v.addr_type = AT_UNKNOWN;
      endcase
      v.next_start = st;
    end else begin
      v.addr_type = AT_UNICAST;
      v.next_start = (st >= NUM_CX) ? st : 4'(NUM_CX);
      for (int c = st; c < NUM_CX && !v.found; c++)
        for (int r = 0; r < RULES_PER_CX && !v.found; r++) begin
          rule_t e;
          e = table_q[c * RULES_PER_CX + r];
          m = plen_mask(e.plen);
          if (e.valid && e.dscp == ds && (e.version == 2'd1 || e.version == 2'd2) &&
              addr != '0 && ((addr ^ {e.hi, e.lo}) & m) == '0) begin
            v.found = 1'b1;
            v.cx = 3'(c);
            v.next_start = 4'(c + 1);
          end
        end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
      verdicts_q.delete();
      foreach (table_q[i]) table_q[i].valid = 1'b0;
    end else begin
      if (in_tvalid && in_tready) verdicts_q.push_back(classify(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (verdicts_q.size() == 0) begin
          $error("unexpected result tdata=%h tuser=%h", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          verdict_t w;
          int bad;
          w = verdicts_q.pop_front();
          bad = 0;
          if (out_tuser != w.addr_type) begin
            $error("addr_type exp %0d got %0d", w.addr_type, out_tuser); bad++;
          end
          if (out_tdata[0] != w.found) begin
            $error("found exp %0d got %0d", w.found, out_tdata[0]); bad++;
          end
          if (out_tdata[3:1] != w.cx) begin
            $error("cx_index exp %0d got %0d", w.cx, out_tdata[3:1]); bad++;
          end
          if (out_tdata[7:4] != w.next_start) begin
            $error("next_start exp %0d got %0d", w.next_start, out_tdata[7:4]); bad++;
          end
          fail_count <= fail_count + bad;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_ipv6_prefix_classifier.sv =====
// tb_ipv6_prefix_classifier: drives writes and lookups into the classifier,
// random gaps on both channels, verdict from ipc_scoreboard. Depends on ipc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb_ipv6_prefix_classifier;
  import ipc_pkg::*;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [159:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  int fail_count, pending, cycles;
  int out_gap;
  logic [127:0] rule_addr[SLOTS];
  logic [63:0] slot_written;

  ipv6_prefix_classifier i_dut (.*);
  ipc_scoreboard i_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 30) out_gap <= gap();
    end
  end

  task automatic send(logic op, logic [159:0] d);
    int g;
    g = gap();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic put_rule(logic [5:0] idx, logic [127:0] a, logic [5:0] ds,
                          logic [1:0] ver, logic [7:0] plen, logic en);
    rule_addr[idx] = a;
    slot_written[idx] = 1'b1;
    send(OP_WRITE, {5'b0, en, plen, ver, idx, 4'($urandom_range(0, 15)), ds,
                    a[63:0], a[127:64]});
  endtask

  task automatic lookup(logic [127:0] a, logic [5:0] ds, logic [3:0] st);
    send(OP_CLASSIFY, {5'b0, 17'($urandom), st, ds, a[63:0], a[127:64]});
  endtask

  function automatic logic [127:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    logic [127:0] a;
    int s;
    cycles = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    slot_written = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // empty table, multicast scopes, all-zero and extreme starts
    lookup({128{1'b1}}, 6'd63, 4'd0);
    lookup(128'hFF02 << 112, 6'd0, 4'd15);
    lookup(128'hFF0E << 112, 6'd1, 4'd3);
    lookup(128'hFF05 << 112, 6'd1, 4'd8);
    lookup('0, 6'd0, 4'd0);
    lookup(128'h2001 << 112, 6'd0, 4'd9);
    put_rule(6'd0, {128{1'b1}}, 6'd63, 2'd2, 8'd255, 1'b1);
    put_rule(6'd63, 128'h2001_0db8 << 96, 6'd0, 2'd1, 8'd0, 1'b1);
    put_rule(6'd9, 128'h2001_0db8 << 96, 6'd5, 2'd0, 8'd32, 1'b1);
    put_rule(6'd10, 128'h2001_0db8 << 96, 6'd5, 2'd3, 8'd32, 1'b1);
    put_rule(6'd11, 128'h2001_0db8 << 96, 6'd5, 2'd1, 8'd32, 1'b0);
    put_rule(6'd12, 128'h2001_0db8 << 96, 6'd5, 2'd2, 8'd64, 1'b1);
    put_rule(6'd13, '0, 6'd5, 2'd1, 8'd128, 1'b1);
    lookup({128{1'b1}} >> 8 | 128'h00 << 120, 6'd63, 4'd0);
    lookup({8'hFE, {120{1'b1}}}, 6'd63, 4'd0);
    lookup(128'h2001_0db8_0000_0000_1234 << 48, 6'd5, 4'd0);
    lookup(128'h7, 6'd0, 4'd1);
    lookup('0, 6'd5, 4'd0);
    lookup(128'h2001_0db8 << 96, 6'd5, 4'd2);
    // drain before the random part
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1000; n++) begin
      s = $urandom_range(0, 99);
      if (s < 30) begin
        a = rand_addr();
        if ($urandom_range(0, 3) == 0) a[127:120] = 8'hFF;
        put_rule(6'($urandom), a, 6'($urandom_range(0, 3)), 2'($urandom),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 128)),
                 ($urandom_range(0, 4) != 0));
      end else if (s < 75 && slot_written != '0) begin
        int idx;
        do idx = $urandom_range(0, SLOTS - 1); while (!slot_written[idx]);
        a = rule_addr[idx] ^ (rand_addr() >> $urandom_range(0, 128));
        lookup(a, 6'($urandom_range(0, 3)), 4'($urandom_range(0, 9)));
      end else if (s < 85) begin
        a = rand_addr();
        a[127:120] = 8'hFF;
        lookup(a, 6'($urandom), 4'($urandom));
      end else begin
        lookup(rand_addr(), 6'($urandom), 4'($urandom));
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
